FILE: rtl/pdqs_pkg.sv
// ----------------------------------------------------------------------------
// pdqs_pkg
// Types and codes shared by the position deque with membership search.
// ----------------------------------------------------------------------------
package pdqs_pkg;

    localparam int OP_W     = 3;
    localparam int FIELD_W  = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  out_x;
        logic [FIELD_W-1:0]  out_y;
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SRCH,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/pdqs_ram.sv
// ----------------------------------------------------------------------------
// pdqs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pdqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/position_deque_with_search_top.sv
// ----------------------------------------------------------------------------
// position_deque_with_search_top
// Bounded double-ended queue of x/y positions held in a ring RAM, with a
// membership search that walks the held entries one per cycle.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one operation per transfer (push front, pop rear,
//   query, read front, clear); m_ channel returns exactly one result per
//   operation with coordinates, found flag, status and occupancy.
//   one operation is worked at a time; s_ready is high only while idle.
//   after the input transfer each operation runs the exec state; push,
//   clear, unused codes and empty or full cases then go to the done state,
//   pop and read front pass a RAM read wait state first, and a query
//   walks the search state, comparing entries up to and including a match
//   (at most the occupancy) through the single RAM read port and comparator.
//   the block is ready again in the cycle the result is presented.
//   reset clears head, tail, count, the sequencer and the output valid
//   flag; the RAM contents are not cleared, only written entries are used.
//   a result held in the output register waits for m_ready; a new input
//   is still taken and worked, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module position_deque_with_search_top #(
    parameter int DEPTH      = 256,
    parameter int COORD_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdqs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pdqs_pkg::out_item_t m_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (COORD_BITS < pdqs_pkg::FIELD_W) ? COORD_BITS : pdqs_pkg::FIELD_W;

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    pdqs_pkg::state_t              state_reg, state_next;
    logic [pdqs_pkg::OP_W-1:0]     op_reg, op_next;
    logic [SW-1:0]                 px_reg, px_next;
    logic [SW-1:0]                 py_reg, py_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [AW-1:0]                 tail_reg, tail_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 slot_reg, slot_next;
    logic [CW-1:0]                 cmp_reg, cmp_next;
    logic [SW-1:0]                 res_x_reg, res_x_next;
    logic [SW-1:0]                 res_y_reg, res_y_next;
    logic                          res_found_reg, res_found_next;
    logic [pdqs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          m_valid_reg, m_valid_next;
    pdqs_pkg::out_item_t           m_data_reg, m_data_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [2*SW-1:0]               ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [2*SW-1:0]               ram_rdata;
    logic [SW-1:0]                 rd_x, rd_y;
    logic                          is_empty, is_full, out_free, hit, last_cmp;

    pdqs_ram #(
        .WIDTH (2 * SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x     = ram_rdata[2*SW-1:SW];
    assign rd_y     = ram_rdata[SW-1:0];
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = (rd_x == px_reg) && (rd_y == py_reg);
    assign last_cmp = ((cmp_reg + CW'(1)) == count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pdqs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pdqs_pkg::ST_EXEC;
                end
            end
            pdqs_pkg::ST_EXEC: begin
                state_next = pdqs_pkg::ST_DONE;
                if (!is_empty && (op_reg == pdqs_pkg::OP_POP_REAR ||
                                  op_reg == pdqs_pkg::OP_READ_FRONT)) begin
                    state_next = pdqs_pkg::ST_RDWAIT;
                end
                if (!is_empty && op_reg == pdqs_pkg::OP_QUERY) begin
                    state_next = pdqs_pkg::ST_SRCH;
                end
            end
            pdqs_pkg::ST_RDWAIT: begin
                state_next = pdqs_pkg::ST_DONE;
            end
            pdqs_pkg::ST_SRCH: begin
                if (hit || last_cmp) begin
                    state_next = pdqs_pkg::ST_DONE;
                end
            end
            pdqs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pdqs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdqs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next         = op_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        cmp_next        = cmp_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = {px_reg, py_reg};
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            pdqs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next = s_data.op;
                    px_next = s_data.pos_x[SW-1:0];
                    py_next = s_data.pos_y[SW-1:0];
                end
            end
            pdqs_pkg::ST_EXEC: begin
                res_x_next      = '0;
                res_y_next      = '0;
                res_found_next  = 1'b0;
                res_status_next = pdqs_pkg::STATUS_OK;
                unique case (op_reg)
                    pdqs_pkg::OP_PUSH_FRONT: begin
                        if (is_full) begin
                            res_status_next = pdqs_pkg::STATUS_FULL;
                        end else begin
                            if (is_empty) begin
                                tail_next = head_reg;
                                ram_waddr = head_reg;
                            end else begin
                                head_next = ring_prev(head_reg);
                                ram_waddr = ring_prev(head_reg);
                            end
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    pdqs_pkg::OP_POP_REAR: begin
                        if (is_empty) begin
                            res_status_next = pdqs_pkg::STATUS_EMPTY;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = tail_reg;
                            tail_next  = ring_prev(tail_reg);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    pdqs_pkg::OP_QUERY: begin
                        ram_re    = 1'b1;
                        ram_raddr = head_reg;
                        slot_next = ring_next(head_reg);
                        cmp_next  = '0;
                    end
                    pdqs_pkg::OP_READ_FRONT: begin
                        if (is_empty) begin
                            res_status_next = pdqs_pkg::STATUS_EMPTY;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = head_reg;
                        end
                    end
                    pdqs_pkg::OP_CLEAR: begin
                        count_next = '0;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                    default: begin
                    end
                endcase
            end
            pdqs_pkg::ST_RDWAIT: begin
                res_x_next = rd_x;
                res_y_next = rd_y;
            end
            pdqs_pkg::ST_SRCH: begin
                // one entry compared per cycle, next read issued alongside
                ram_re    = 1'b1;
                ram_raddr = slot_reg;
                slot_next = ring_next(slot_reg);
                cmp_next  = cmp_reg + CW'(1);
                if (hit) begin
                    res_found_next = 1'b1;
                end
            end
            pdqs_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.out_x     = pdqs_pkg::FIELD_W'(res_x_reg);
                    m_data_next.out_y     = pdqs_pkg::FIELD_W'(res_y_reg);
                    m_data_next.found     = res_found_reg;
                    m_data_next.status    = res_status_reg;
                    m_data_next.occupancy = pdqs_pkg::OCC_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdqs_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        slot_reg       <= slot_next;
        cmp_reg        <= cmp_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == pdqs_pkg::STATUS_FULL)
            |-> (m_data.occupancy == pdqs_pkg::OCC_W'(DEPTH)))
        else $error("full status with queue not full");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == pdqs_pkg::STATUS_EMPTY)
            |-> (m_data.occupancy == '0 && m_data.out_x == '0 && m_data.out_y == '0))
        else $error("empty status with entries held");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pdqs_pkg::ST_EXEC && op_reg == pdqs_pkg::OP_CLEAR)
            |=> (count_reg == '0 && head_reg == '0 && tail_reg == '0))
        else $error("clear left entries behind");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found)
            |-> (m_data.status == pdqs_pkg::STATUS_OK && m_data.occupancy != '0))
        else $error("found flag on empty queue");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the position deque with membership search. A
// scoreboard class keeps its own copy of the ring store and predicts the
// result of every operation taken on the input channel. Each result taken
// on the output channel is checked field by field against the oldest
// prediction. Stimulus is a short directed list followed by random bursts:
// mixed operations, fills to full, drains to empty, with random idling on
// both channels, a long output stall and a pause until fully drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 256;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 1500;

    // codes with no operation behind them
    localparam logic [pdqs_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [pdqs_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [pdqs_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    class deque_scoreboard;
        logic [pdqs_pkg::FIELD_W-1:0] held_x [DEPTH];
        logic [pdqs_pkg::FIELD_W-1:0] held_y [DEPTH];
        logic [SLOT_W-1:0]            head_slot;
        logic [SLOT_W-1:0]            tail_slot;
        logic [pdqs_pkg::OCC_W-1:0]   count;
        pdqs_pkg::out_item_t          awaited [$];
        int unsigned                  errors;

        function new();
            head_slot = '0;
            tail_slot = '0;
            count     = '0;
            errors    = 0;
            foreach (held_x[i]) begin
                held_x[i] = '0;
                held_y[i] = '0;
            end
        endfunction

        function pdqs_pkg::out_item_t predict_result(pdqs_pkg::in_item_t it);
            pdqs_pkg::out_item_t r;
            logic [SLOT_W-1:0]   slot;
            r = '0;
            case (it.op)
                pdqs_pkg::OP_PUSH_FRONT: begin
                    if (count >= DEPTH) begin
                        r.status = pdqs_pkg::STATUS_FULL;
                    end else begin
                        if (count == 0) tail_slot = head_slot;
                        else head_slot = head_slot - 1'b1;
                        held_x[head_slot] = it.pos_x;
                        held_y[head_slot] = it.pos_y;
                        count++;
                    end
                end
                pdqs_pkg::OP_POP_REAR: begin
                    if (count == 0) begin
                        r.status = pdqs_pkg::STATUS_EMPTY;
                    end else begin
                        r.out_x   = held_x[tail_slot];
                        r.out_y   = held_y[tail_slot];
                        tail_slot = tail_slot - 1'b1;
                        count--;
                    end
                end
                pdqs_pkg::OP_QUERY: begin
                    slot = head_slot;
                    for (int i = 0; i < count; i++) begin
                        if (held_x[slot] == it.pos_x && held_y[slot] == it.pos_y) begin
                            r.found = 1'b1;
                            break;
                        end
                        slot = slot + 1'b1;
                    end
                end
                pdqs_pkg::OP_READ_FRONT: begin
                    if (count == 0) begin
                        r.status = pdqs_pkg::STATUS_EMPTY;
                    end else begin
                        r.out_x = held_x[head_slot];
                        r.out_y = held_y[head_slot];
                    end
                end
                pdqs_pkg::OP_CLEAR: begin
                    count     = '0;
                    head_slot = '0;
                    tail_slot = '0;
                end
                default: ;
            endcase
            r.occupancy = count;
            return r;
        endfunction

        function void note_operation(pdqs_pkg::in_item_t it);
            awaited.push_back(predict_result(it));
        endfunction

        function void pick_held(output logic [pdqs_pkg::FIELD_W-1:0] x,
                                output logic [pdqs_pkg::FIELD_W-1:0] y);
            logic [SLOT_W-1:0] slot;
            slot = head_slot + SLOT_W'($urandom_range(count - 1));
            x = held_x[slot];
            y = held_y[slot];
        endfunction

        function void check_result(pdqs_pkg::out_item_t got);
            pdqs_pkg::out_item_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing outstanding: %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.found !== want.found || got.status !== want.status ||
                got.occupancy !== want.occupancy) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected x=%0d y=%0d found=%0b status=%0d occ=%0d",
                             want.out_x, want.out_y, want.found, want.status, want.occupancy);
                    $display("          actual   x=%0d y=%0d found=%0b status=%0d occ=%0d",
                             got.out_x, got.out_y, got.found, got.status, got.occupancy);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    pdqs_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    pdqs_pkg::out_item_t m_data;

    deque_scoreboard sb;
    int unsigned     items_sent;
    bit              steady_run;
    bit              hold_request;
    bit              hold_done;

    position_deque_with_search_top #(
        .DEPTH      (DEPTH),
        .COORD_BITS (pdqs_pkg::FIELD_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic pdqs_pkg::in_item_t make_item(logic [pdqs_pkg::OP_W-1:0] op,
                                                     int x, int y);
        pdqs_pkg::in_item_t it;
        it.op    = op;
        it.pos_x = pdqs_pkg::FIELD_W'(x);
        it.pos_y = pdqs_pkg::FIELD_W'(y);
        return it;
    endfunction

    function automatic int random_coord();
        if ($urandom_range(99) < 25) return $urandom_range(3);
        return $urandom_range(255);
    endfunction

    function automatic pdqs_pkg::in_item_t query_item();
        logic [pdqs_pkg::FIELD_W-1:0] x;
        logic [pdqs_pkg::FIELD_W-1:0] y;
        if (sb.count != 0 && $urandom_range(1) == 1) begin
            sb.pick_held(x, y);
            return make_item(pdqs_pkg::OP_QUERY, x, y);
        end
        return make_item(pdqs_pkg::OP_QUERY, random_coord(), random_coord());
    endfunction

    function automatic pdqs_pkg::in_item_t random_operation();
        int unsigned w;
        w = $urandom_range(99);
        if (w < 30) return make_item(pdqs_pkg::OP_PUSH_FRONT, random_coord(), random_coord());
        if (w < 50) return make_item(pdqs_pkg::OP_POP_REAR, random_coord(), random_coord());
        if (w < 70) return query_item();
        if (w < 84) return make_item(pdqs_pkg::OP_READ_FRONT, random_coord(), random_coord());
        if (w < 88) return make_item(pdqs_pkg::OP_CLEAR, random_coord(), random_coord());
        return make_item(pdqs_pkg::OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7)),
                         random_coord(), random_coord());
    endfunction

    task automatic offer_operation(input pdqs_pkg::in_item_t it);
        steady_run = (items_sent >= 600 && items_sent < 800);
        if (items_sent == 300) hold_request = 1'b1;
        if (!steady_run && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_operation(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.awaited.size() != 0);
    endtask

    task automatic mixed_burst(input int unsigned n);
        repeat (n) offer_operation(random_operation());
    endtask

    task automatic fill_queue();
        while (sb.count < DEPTH) begin
            if ($urandom_range(99) < 10) offer_operation(query_item());
            else offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, random_coord(),
                                           random_coord()));
        end
        repeat ($urandom_range(1, 3)) begin
            offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, random_coord(), random_coord()));
        end
        offer_operation(query_item());
    endtask

    task automatic drain_queue();
        int unsigned w;
        while (sb.count != 0) begin
            w = $urandom_range(99);
            if (w < 80) offer_operation(make_item(pdqs_pkg::OP_POP_REAR, random_coord(),
                                                  random_coord()));
            else if (w < 90) offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 0, 0));
            else offer_operation(query_item());
        end
        repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(1) == 1) begin
                offer_operation(make_item(pdqs_pkg::OP_POP_REAR, 255, 255));
            end else begin
                offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 255, 255));
            end
        end
    endtask

    // output side: random back-pressure, one long stall on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 1000;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady_run) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) sb.check_result(m_data);
    end

    initial begin
        int unsigned pick;
        int unsigned guard;
        bit          paused;
        sb           = new();
        items_sent   = 0;
        steady_run   = 1'b0;
        hold_request = 1'b0;
        paused       = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, coordinate extremes, rear match, unused codes
        offer_operation(make_item(pdqs_pkg::OP_POP_REAR, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, 255, 255));
        offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 255, 255));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 0, 255));
        offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, 'haa, 'h55));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 'haa, 'h55));
        offer_operation(make_item(pdqs_pkg::OP_POP_REAR, 0, 0));
        offer_operation(make_item(OP_RSVD_5, 255, 255));
        offer_operation(make_item(OP_RSVD_6, 'h55, 'haa));
        offer_operation(make_item(OP_RSVD_7, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_CLEAR, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_QUERY, 255, 255));
        offer_operation(make_item(pdqs_pkg::OP_PUSH_FRONT, 1, 2));
        offer_operation(make_item(pdqs_pkg::OP_READ_FRONT, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_POP_REAR, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_POP_REAR, 0, 0));
        offer_operation(make_item(pdqs_pkg::OP_CLEAR, 255, 255));

        fill_queue();
        drain_queue();
        while (items_sent < RANDOM_ITEMS + 23) begin
            if (!paused && items_sent >= 1000) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 65) mixed_burst($urandom_range(10, 40));
            else if (pick < 75) fill_queue();
            else if (pick < 90) drain_queue();
            else if (pick < 95) offer_operation(make_item(pdqs_pkg::OP_CLEAR, random_coord(), 0));
            else wait_drained();
        end
        s_valid <= 1'b0;

        guard = 0;
        while (sb.awaited.size() != 0 && guard < 400000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
